// File: hdl/pressure_sensor_compensation_defines.svh
// assertion macros shared by the pressure compensation block
`ifndef PRESSURE_SENSOR_COMPENSATION_DEFINES_SVH
`define PRESSURE_SENSOR_COMPENSATION_DEFINES_SVH

`ifndef NO_ASSERTIONS
// full property, clocked on clk and held off during reset
`define PSC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("psc assertion failed");
// same-cycle implication
`define PSC_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("psc implication failed");
`else
`define PSC_ASSERT(label, prop)
`define PSC_ASSERT_IMPL(label, pre, post)
`endif

`endif

// File: hdl/psc_pkg.sv
// types and constants of the pressure compensation pipeline
package psc_pkg;

  localparam int D_W      = 24;  // raw conversion width
  localparam int COEF_W   = 16;  // calibration word width
  localparam int IDX_W    = 3;   // config register index width
  localparam int DT_W     = 25;  // signed temperature difference
  localparam int PROD_W   = 42;  // dT times a coefficient
  localparam int OFF_W    = 35;
  localparam int SENS_W   = 34;
  localparam int TEMP_W   = 19;
  localparam int PRES_W   = 23;

  localparam int OFF_SHIFT  = 7;
  localparam int SENS_SHIFT = 8;
  localparam int TEMP_SHIFT = 23;
  localparam int P_SHIFT1   = 21;
  localparam int P_SHIFT2   = 15;

  // d1 * sens split into two partial products
  localparam int LO_W   = 17;
  localparam int HI_W   = SENS_W - LO_W;
  localparam int PPL_W  = D_W + LO_W;
  localparam int PPH_W  = D_W + 1 + HI_W;
  localparam int MULT_W = PPH_W + LO_W;
  localparam int DIFF_W = MULT_W - P_SHIFT1;

  localparam logic signed [TEMP_W-1:0] TEMP_BASE = 19'sd2000;

  typedef enum logic [IDX_W-1:0] {
    REG_SENS_COEFF        = 3'd0,
    REG_OFFSET_COEFF      = 3'd1,
    REG_SENS_TEMP_COEFF   = 3'd2,
    REG_OFFSET_TEMP_COEFF = 3'd3,
    REG_REF_TEMP          = 3'd4,
    REG_TEMP_SLOPE        = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [COEF_W-1:0] sens_coeff;
    logic [COEF_W-1:0] offset_coeff;
    logic [COEF_W-1:0] sens_temp_coeff;
    logic [COEF_W-1:0] offset_temp_coeff;
    logic [COEF_W-1:0] ref_temp;
    logic [COEF_W-1:0] temp_slope;
  } cfg_t;

  typedef struct packed {
    logic [D_W-1:0]           d1;
    logic signed [PROD_W-1:0] p_off;
    logic signed [PROD_W-1:0] p_sens;
    logic signed [PROD_W-1:0] p_temp;
  } delta_t;

  typedef struct packed {
    logic [D_W-1:0]           d1;
    logic signed [OFF_W-1:0]  off;
    logic signed [SENS_W-1:0] sens;
    logic signed [TEMP_W-1:0] temp;
  } comp_t;

endpackage

// File: hdl/psc_in_if.sv
// raw sample channel
interface psc_in_if import psc_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [D_W-1:0] pressure_raw;
  logic [D_W-1:0] temp_raw;

  modport source (output valid, pressure_raw, temp_raw, input ready);
  modport sink (input valid, pressure_raw, temp_raw, output ready);
endinterface

// File: hdl/psc_out_if.sv
// compensated result channel
interface psc_out_if import psc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature;
  logic signed [PRES_W-1:0] pressure;

  modport source (output valid, temperature, pressure, input ready);
  modport sink (input valid, temperature, pressure, output ready);
endinterface

// File: hdl/pressure_sensor_compensation.sv
// top level: calibration registers and the six-stage compensation pipeline
// throughput: one sample transaction per cycle while the output is not blocked, set by the fully pipelined multipliers
// stalls ripple back stage by stage; empty stages keep filling while the output waits
// reset (synchronous, active high) empties the pipeline and clears all coefficients to 0
`include "pressure_sensor_compensation_defines.svh"
module pressure_sensor_compensation import psc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  psc_in_if.sink            sample,
  psc_out_if.source         result,
  input  logic              cfg_wr_en,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [COEF_W-1:0] cfg_wdata
);

  // calibration words C1..C6
  cfg_t   cfg;

  // inter-module handshake and payload
  logic   dl_valid, dl_ready;
  delta_t dl_data;
  logic   cb_valid, cb_ready;
  comp_t  cb_data;

  // config writes; indexes past the last register are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_index))
        REG_SENS_COEFF:        cfg.sens_coeff        <= cfg_wdata;
        REG_OFFSET_COEFF:      cfg.offset_coeff      <= cfg_wdata;
        REG_SENS_TEMP_COEFF:   cfg.sens_temp_coeff   <= cfg_wdata;
        REG_OFFSET_TEMP_COEFF: cfg.offset_temp_coeff <= cfg_wdata;
        REG_REF_TEMP:          cfg.ref_temp          <= cfg_wdata;
        REG_TEMP_SLOPE:        cfg.temp_slope        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stages 1-2: dT = D2 - C5*256, then dT*C4, dT*C3, dT*C6
  psc_delta u_delta (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .d1_in     (sample.pressure_raw),
    .d2_in     (sample.temp_raw),
    .out_valid (dl_valid),
    .out_ready (dl_ready),
    .out_data  (dl_data)
  );

  // stage 3: OFF, SENS and TEMP with floor shifts
  psc_combine u_combine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (dl_valid),
    .in_ready  (dl_ready),
    .in_data   (dl_data),
    .out_valid (cb_valid),
    .out_ready (cb_ready),
    .out_data  (cb_data)
  );

  // stages 4-6: D1*SENS as two partial products, sum, subtract OFF, output register
  psc_pressure u_pressure (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (cb_valid),
    .in_ready    (cb_ready),
    .in_data     (cb_data),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .temperature (result.temperature),
    .pressure    (result.pressure)
  );

  // input only stalls when every stage is full and the output is blocked
  `PSC_ASSERT_IMPL(a_stall_only_when_full, !sample.ready, result.valid && !result.ready)

endmodule

// File: hdl/psc_delta.sv
// stages 1-2: temperature difference and its three coefficient products
`include "pressure_sensor_compensation_defines.svh"
module psc_delta import psc_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  cfg_t           cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [D_W-1:0] d1_in,
  input  logic [D_W-1:0] d2_in,
  output logic           out_valid,
  input  logic           out_ready,
  output delta_t         out_data
);

  logic                     v1, v2, r1, r2;
  logic [D_W-1:0]           d1_s1;
  logic signed [DT_W-1:0]   dt_s1, dt_next;
  logic signed [COEF_W:0]   c3s, c4s, c6s;
  logic signed [PROD_W-1:0] p_off_next, p_sens_next, p_temp_next;

  assign r2       = !v2 || out_ready;
  assign r1       = !v1 || r2;
  assign in_ready = r1;

  assign dt_next = $signed({1'b0, d2_in}) - $signed({1'b0, cfg.ref_temp, 8'b0});

  assign c3s = $signed({1'b0, cfg.sens_temp_coeff});
  assign c4s = $signed({1'b0, cfg.offset_temp_coeff});
  assign c6s = $signed({1'b0, cfg.temp_slope});

  assign p_off_next  = PROD_W'(dt_s1) * PROD_W'(c4s);
  assign p_sens_next = PROD_W'(dt_s1) * PROD_W'(c3s);
  assign p_temp_next = PROD_W'(dt_s1) * PROD_W'(c6s);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && in_valid) begin
      d1_s1 <= d1_in;
      dt_s1 <= dt_next;
    end
    if (r2 && v1) begin
      out_data.d1     <= d1_s1;
      out_data.p_off  <= p_off_next;
      out_data.p_sens <= p_sens_next;
      out_data.p_temp <= p_temp_next;
    end
  end

  assign out_valid = v2;

  `PSC_ASSERT(a_accept_fills_stage1, in_valid && in_ready |=> v1)

endmodule

// File: hdl/psc_combine.sv
// stage 3: offset, sensitivity and temperature sums
module psc_combine import psc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  logic   in_valid,
  output logic   in_ready,
  input  delta_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output comp_t  out_data
);

  logic                     v3, r3;
  logic signed [OFF_W-1:0]  off_next;
  logic signed [SENS_W-1:0] sens_next;
  logic signed [TEMP_W-1:0] temp_next;

  assign r3       = !v3 || out_ready;
  assign in_ready = r3;

  // arithmetic shifts taken as part-selects of the signed products
  assign off_next  = $signed({3'b0, cfg.offset_coeff, 16'b0})
                   + $signed(in_data.p_off[PROD_W-1:OFF_SHIFT]);
  assign sens_next = $signed({3'b0, cfg.sens_coeff, 15'b0})
                   + $signed(in_data.p_sens[PROD_W-1:SENS_SHIFT]);
  assign temp_next = TEMP_BASE + $signed(in_data.p_temp[PROD_W-1:TEMP_SHIFT]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (r3) begin
      v3 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r3 && in_valid) begin
      out_data.d1   <= in_data.d1;
      out_data.off  <= off_next;
      out_data.sens <= sens_next;
      out_data.temp <= temp_next;
    end
  end

  assign out_valid = v3;

endmodule

// File: hdl/psc_pressure.sv
// stages 4-6: split pressure product, sum, offset removal and output register
`include "pressure_sensor_compensation_defines.svh"
module psc_pressure import psc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  comp_t                    in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [TEMP_W-1:0] temperature,
  output logic signed [PRES_W-1:0] pressure
);

  logic                     v4, v5, v6, r4, r5, r6;
  logic [PPL_W-1:0]         pp_lo, pp_lo_next;
  logic signed [PPH_W-1:0]  pp_hi, pp_hi_next;
  logic signed [OFF_W-1:0]  off4, off5;
  logic signed [TEMP_W-1:0] temp4, temp5;
  logic signed [MULT_W-1:0] prod, prod_next;
  logic signed [DIFF_W-1:0] diff_next;

  assign r6       = !v6 || out_ready;
  assign r5       = !v5 || r6;
  assign r4       = !v4 || r5;
  assign in_ready = r4;

  // low part unsigned, high part carries the sign of sens
  assign pp_lo_next = PPL_W'(in_data.d1) * PPL_W'(in_data.sens[LO_W-1:0]);
  assign pp_hi_next = PPH_W'($signed({1'b0, in_data.d1}))
                    * PPH_W'($signed(in_data.sens[SENS_W-1:LO_W]));

  assign prod_next = $signed({pp_hi, {LO_W{1'b0}}})
                   + $signed({{(MULT_W-PPL_W){1'b0}}, pp_lo});

  assign diff_next = $signed(prod[MULT_W-1:P_SHIFT1]) - DIFF_W'(off5);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (r4) v4 <= in_valid;
      if (r5) v5 <= v4;
      if (r6) v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (r4 && in_valid) begin
      pp_lo <= pp_lo_next;
      pp_hi <= pp_hi_next;
      off4  <= in_data.off;
      temp4 <= in_data.temp;
    end
    if (r5 && v4) begin
      prod  <= prod_next;
      off5  <= off4;
      temp5 <= temp4;
    end
    if (r6 && v5) begin
      temperature <= temp5;
      pressure    <= $signed(diff_next[DIFF_W-1:P_SHIFT2]);
    end
  end

  assign out_valid = v6;

  `PSC_ASSERT_IMPL(a_backpressure_full, !in_ready, v4 && v5 && v6 && !out_ready)

endmodule

// File: tb/sv/pressure_sensor_compensation_tb.sv
// self-checking testbench for the pressure sensor compensation pipeline
`timescale 1ns / 1ps

module pressure_sensor_compensation_tb;
  import psc_pkg::*;

  // clock, run limits
  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 3;
  localparam int DRAIN_CYCLES = 20;       // longer than the pipeline, leave margin
  localparam int CYCLE_LIMIT  = 400_000;  // a run that reaches this limit ends as failed
  localparam int RAND_PHASES  = 6;
  localparam int PHASE_ITEMS  = 225;

  // register indexes past the last coefficient, writes there must be dropped
  localparam logic [IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] IDX_SPARE_HI = 3'd7;

  // one compensated reading as seen on the result channel
  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic signed [PRES_W-1:0] pressure;
  } reading_t;

  // directed row: calibration set, raw sample, optional hand-written answer
  typedef struct {
    int unsigned    cal_set;
    logic [D_W-1:0] pressure_raw;
    logic [D_W-1:0] temp_raw;
    bit             fixed_result;
    reading_t       result_value;
  } probe_t;

  // receiver stall behavior, redrawn by the result sink when its current stretch ends
  typedef enum int {RX_STREAM, RX_CHOPPY, RX_SLOW} rx_mode_t;

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic [IDX_W-1:0]  cfg_index;
  logic [COEF_W-1:0] cfg_wdata;

  psc_in_if  sample();
  psc_out_if result();

  pressure_sensor_compensation i_dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample),
    .result    (result),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // shadow of the calibration words as the block should hold them
  cfg_t     cal;
  reading_t expected_readings[$];
  int       mismatches;
  int       cycle_count;
  int       burst_left;

  // calibration sets used by the directed rows
  // set 0 is the reset state, set 1 every word at full scale,
  // set 2 a typical factory calibration, sets 3 and 4 mixed extremes
  cfg_t cal_sets [5] = '{
    '{16'd0,     16'd0,     16'd0,     16'd0,     16'd0,     16'd0},
    '{16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF},
    '{16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165},
    '{16'd0,     16'hFFFF,  16'hFFFF,  16'd0,     16'd0,     16'hFFFF},
    '{16'hFFFF,  16'd0,     16'd0,     16'hFFFF,  16'hFFFF,  16'd0}
  };

  // directed rows; with all words zero the answer is always 20.00 degC and 0 mbar
  probe_t probes [21] = '{
    '{0, 24'h000000, 24'h000000, 1'b1, '{19'sd2000, 23'sd0}},
    '{0, 24'hFFFFFF, 24'hFFFFFF, 1'b1, '{19'sd2000, 23'sd0}},
    '{0, 24'hFFFFFF, 24'h000000, 1'b1, '{19'sd2000, 23'sd0}},
    '{0, 24'h000000, 24'hFFFFFF, 1'b1, '{19'sd2000, 23'sd0}},
    '{0, 24'hAAAAAA, 24'h555555, 1'b1, '{19'sd2000, 23'sd0}},
    // full-scale words: most negative and most positive dT
    '{1, 24'h000000, 24'h000000, 1'b0, '0},
    '{1, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0},
    '{1, 24'hFFFFFF, 24'h000000, 1'b0, '0},
    '{1, 24'h000000, 24'hFFFFFF, 1'b0, '0},
    '{1, 24'h800000, 24'hFFFF00, 1'b0, '0},   // dT exactly zero
    // typical calibration, including a reading at the reference temperature
    '{2, 24'd4311550, 24'd8387300, 1'b0, '0},
    '{2, 24'd4311550, 24'd8077568, 1'b0, '0},
    '{2, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0},
    '{2, 24'h000000, 24'h000000, 1'b0, '0},
    '{2, 24'd6000000, 24'd9000000, 1'b0, '0},
    '{3, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0},
    '{3, 24'hFFFFFF, 24'h000000, 1'b0, '0},
    '{3, 24'h123456, 24'h800000, 1'b0, '0},
    '{4, 24'hFFFFFF, 24'h000000, 1'b0, '0},
    '{4, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0},
    '{4, 24'h000001, 24'h000001, 1'b0, '0}
  };

  // first-order compensation in exact 64-bit integers
  // >>> on a signed longint floors, matching the block's arithmetic shifts
  function automatic reading_t compensate(cfg_t c, logic [D_W-1:0] d1,
                                          logic [D_W-1:0] d2);
    longint dt, off, sens, temp, pres;
    reading_t r;
    dt   = longint'(d2) - longint'(c.ref_temp) * 256;
    off  = longint'(c.offset_coeff) * 65536
         + ((dt * longint'(c.offset_temp_coeff)) >>> OFF_SHIFT);
    sens = longint'(c.sens_coeff) * 32768
         + ((dt * longint'(c.sens_temp_coeff)) >>> SENS_SHIFT);
    temp = 2000 + ((dt * longint'(c.temp_slope)) >>> TEMP_SHIFT);
    pres = (((longint'(d1) * sens) >>> P_SHIFT1) - off) >>> P_SHIFT2;
    r.temperature = temp[TEMP_W-1:0];
    r.pressure    = pres[PRES_W-1:0];
    return r;
  endfunction

  // calibration word: zero, full scale or anything
  function automatic logic [COEF_W-1:0] pick_coeff();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return COEF_W'($urandom);
    endcase
  endfunction

  // raw conversion: the ends of the range or anything
  function automatic logic [D_W-1:0] pick_raw();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return D_W'($urandom);
    endcase
  endfunction

  always #HALF_PERIOD clk = ~clk;

  // cycle budget; a hang anywhere ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // one register write; wr_en stays high so back-to-back writes need no toggle
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_SENS_COEFF:        cal.sens_coeff        = data;
      REG_OFFSET_COEFF:      cal.offset_coeff      = data;
      REG_SENS_TEMP_COEFF:   cal.sens_temp_coeff   = data;
      REG_OFFSET_TEMP_COEFF: cal.offset_temp_coeff = data;
      REG_REF_TEMP:          cal.ref_temp          = data;
      REG_TEMP_SLOPE:        cal.temp_slope        = data;
      default: ;  // spare index, ignored
    endcase
  endtask

  // load all six words, then hit the spare indexes with junk
  task automatic apply_cal(input cfg_t c);
    write_reg(REG_SENS_COEFF,        c.sens_coeff);
    write_reg(REG_OFFSET_COEFF,      c.offset_coeff);
    write_reg(REG_SENS_TEMP_COEFF,   c.sens_temp_coeff);
    write_reg(REG_OFFSET_TEMP_COEFF, c.offset_temp_coeff);
    write_reg(REG_REF_TEMP,          c.ref_temp);
    write_reg(REG_TEMP_SLOPE,        c.temp_slope);
    write_reg(IDX_SPARE_LO, COEF_W'($urandom));
    write_reg(IDX_SPARE_HI, COEF_W'($urandom));
    cfg_wr_en <= 1'b0;
  endtask

  // stop sending and wait for every outstanding reading to come back
  task automatic settle();
    sample.valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
  endtask

  // sender pacing: bursts of random length, random gaps between them
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        sample.valid        <= 1'b0;
        sample.pressure_raw <= D_W'($urandom);  // junk while idle
        sample.temp_raw     <= D_W'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // one sample transaction; the expectation is queued at the accepting edge
  task automatic send_sample(input logic [D_W-1:0] p_raw, input logic [D_W-1:0] t_raw,
                             input bit fixed_result, input reading_t result_value);
    sample.valid        <= 1'b1;
    sample.pressure_raw <= p_raw;
    sample.temp_raw     <= t_raw;
    do @(posedge clk); while (sample.ready !== 1'b1);
    expected_readings.push_back(fixed_result ? result_value
                                             : compensate(cal, p_raw, t_raw));
    pace();
  endtask

  // result side: stall pattern chosen per stretch, sometimes none at all
  initial begin : result_sink
    int       stall_left;
    int       mode_left;
    rx_mode_t rx_mode;
    result.ready <= 1'b0;
    stall_left = 0;
    mode_left  = 0;
    rx_mode    = RX_STREAM;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      if (stall_left > 0) begin
        result.ready <= 1'b0;
        stall_left--;
      end else begin
        case (rx_mode)
          RX_CHOPPY: stall_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
          RX_SLOW:   stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 20) : 0;
          default:   stall_left = 0;
        endcase
        if (stall_left > 0) begin
          result.ready <= 1'b0;
          stall_left--;
        end else begin
          result.ready <= 1'b1;
        end
      end
    end
  end

  // compare every result transaction against the oldest expectation
  always @(posedge clk) begin : check_results
    reading_t want;
    if (!rst && result.valid && result.ready) begin
      if (expected_readings.size() == 0) begin
        $error("unexpected result transaction: temperature %0d pressure %0d",
               result.temperature, result.pressure);
        mismatches++;
      end else begin
        want = expected_readings.pop_front();
        if (result.temperature !== want.temperature) begin
          $error("temperature mismatch: expected %0d, actual %0d",
                 want.temperature, result.temperature);
          mismatches++;
        end
        if (result.pressure !== want.pressure) begin
          $error("pressure mismatch: expected %0d, actual %0d",
                 want.pressure, result.pressure);
          mismatches++;
        end
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int unsigned    current_set;
    cfg_t           rand_cal;
    logic [D_W-1:0] p_raw;
    logic [D_W-1:0] t_raw;

    clk                 = 1'b0;
    mismatches          = 0;
    cycle_count         = 0;
    burst_left          = 0;
    cal                 = '0;
    current_set         = 0;
    rst                 <= 1'b1;
    cfg_wr_en           <= 1'b0;
    cfg_index           <= '0;
    cfg_wdata           <= '0;
    sample.valid        <= 1'b0;
    sample.pressure_raw <= '0;
    sample.temp_raw     <= '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows; a new calibration set is loaded only once the pipe is empty
    for (int i = 0; i < $size(probes); i++) begin
      if (probes[i].cal_set != current_set) begin
        settle();
        apply_cal(cal_sets[probes[i].cal_set]);
        current_set = probes[i].cal_set;
      end
      send_sample(probes[i].pressure_raw, probes[i].temp_raw,
                  probes[i].fixed_result, probes[i].result_value);
    end

    // random phases, each under a fresh calibration
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      rand_cal.sens_coeff        = pick_coeff();
      rand_cal.offset_coeff      = pick_coeff();
      rand_cal.sens_temp_coeff   = pick_coeff();
      rand_cal.offset_temp_coeff = pick_coeff();
      rand_cal.ref_temp          = pick_coeff();
      rand_cal.temp_slope        = pick_coeff();
      apply_cal(rand_cal);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        p_raw = pick_raw();
        // a good share of temperatures sit near the reference, as on a real part
        if ($urandom_range(0, 3) == 0)
          t_raw = D_W'({cal.ref_temp, 8'h00} + $urandom_range(0, 65535) - 32768);
        else
          t_raw = pick_raw();
        send_sample(p_raw, t_raw, 1'b0, '0);
      end
    end

    // drain, then watch a little longer for stray result transactions
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
